/* rtl/core/utf8fit_pkg.sv */
package utf8fit_pkg;

	localparam int unsigned FACES_DEF = 4;
	localparam int unsigned ENTRIES_DEF = 256;
	localparam int unsigned MAX_BYTES_DEF = 4095;
	localparam int unsigned CODE_W = 21;
	localparam int unsigned ADV_W = 8;
	localparam int unsigned WIDTH_W = 20;
	localparam int unsigned BYTES_W = 12;
	localparam int unsigned ROOM_W = 18;
	localparam int unsigned CNT_W = 9;
	localparam logic [CODE_W-1:0] ELLIPSIS_CODE = 21'h002026;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 20'hFFFFF;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_BYTE = 2'd1,
		OP_END = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_PROC,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} srch_ctl_t;

endpackage

/* rtl/core/utf8fit_search.sv */
module utf8fit_search import utf8fit_pkg::*; #(
	parameter int unsigned FACES = FACES_DEF,
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [$clog2(FACES)+$clog2(ENTRIES)-1:0] wr_addr,
	input logic [CODE_W+ADV_W-1:0] wr_data,
	input logic start,
	input logic [$clog2(FACES)+$clog2(ENTRIES)-1:0] base_addr,
	input logic [$clog2(ENTRIES):0] count,
	input logic [CODE_W-1:0] code,
	output srch_ctl_t ctl,
	output logic [ADV_W-1:0] adv
);
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned AW = $clog2(FACES) + IW;

	logic [CODE_W+ADV_W-1:0] mem [FACES << IW];
	logic [CODE_W+ADV_W-1:0] rd_q;
	logic [IW+1:0] low_q, high_q, mid;
	logic [AW-1:0] base_q;
	logic [CODE_W-1:0] code_q;
	logic busy_q, wait_q, done_q;
	logic [ADV_W-1:0] adv_q;

	assign mid = (low_q + high_q) >> 1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[base_q + AW'(mid[IW-1:0])];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wait_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= (count != '0);
				wait_q <= 1'b0;
				done_q <= (count == '0);
				adv_q <= '0;
				low_q <= '0;
				high_q <= (IW+2)'(count) - 1'b1;
				base_q <= base_addr;
				code_q <= code;
			end else if (busy_q) begin
				if (!wait_q) begin
					wait_q <= 1'b1;
				end else begin
					wait_q <= 1'b0;
					if (rd_q[CODE_W-1:0] == code_q) begin
						adv_q <= rd_q[CODE_W+ADV_W-1:CODE_W];
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else if (rd_q[CODE_W-1:0] < code_q) begin
						if (mid + 1'b1 > high_q) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
						low_q <= mid + 1'b1;
					end else begin
						if (mid == low_q) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
						high_q <= mid - 1'b1;
					end
				end
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign adv = adv_q;
endmodule

/* rtl/core/utf8_text_fit_with_ellipsis_core.sv */
// Channel | Signals                                   | Dir
// in      | in_valid, in_stall, op..avail_width       | input beat
// out     | out_valid, out_stall, fit_bytes..too_long | result beat
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
// A load or unused op needs no search. A byte takes up to two glyph searches,
// a string's first beat one more; each search reads one table entry per probe
// for up to log2(ENTRIES)+1 probes, one after another on the single table read
// port, and no new beat is taken until the sequencer is idle again.
// Reset clears control state and counts; the table is undefined until loaded.
// A stalled result holds the block in its output state.
module utf8_text_fit_with_ellipsis_core import utf8fit_pkg::*; #(
	parameter int unsigned FACES = FACES_DEF,
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] op,
	input logic [1:0] face,
	input logic [7:0] entry_index,
	input logic [20:0] glyph_code,
	input logic [7:0] glyph_advance,
	input logic [7:0] text_byte,
	input logic [15:0] avail_width,
	output logic out_valid,
	input logic out_stall,
	output logic [11:0] fit_bytes,
	output logic [19:0] total_width,
	output logic whole_fits,
	output logic too_long,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [8:0] cfg_data
);
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned FW = $clog2(FACES);
	localparam int unsigned AW = FW + IW;
	localparam int unsigned CAP = (MAX_BYTES < 4095) ? MAX_BYTES : 4095;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q [4];
	logic [CODE_W-1:0] pcode_q;
	logic [1:0] pextra_q;
	logic [BYTES_W-1:0] boff_q, taken_q;
	logic [WIDTH_W-1:0] rw_q;
	logic signed [ROOM_W-1:0] room_q;
	logic instr_q, broken_q, ovf_q;
	logic [1:0] sface_q;
	logic [15:0] savail_q;
	logic [1:0] op_q;
	logic [7:0] byte_q;
	logic fin_end_q;
	logic [BYTES_W-1:0] fin_at_q;

	logic s_start;
	logic [CODE_W-1:0] s_code;
	srch_ctl_t s_ctl;
	logic [ADV_W-1:0] s_adv;
	logic [IW:0] s_count;
	logic face_ok;
	logic [WIDTH_W:0] sum;
	logic [WIDTH_W-1:0] new_rw;
	logic is_cont;
	logic [1:0] lead_extra;
	logic [CODE_W-1:0] lead_code;
	logic take;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign face_ok = (32'(sface_q) < FACES);
	assign s_count = (32'(cnt_q[sface_q]) > ENTRIES) ? (IW+1)'(ENTRIES)
		: (IW+1)'(cnt_q[sface_q]);

	utf8fit_search #(.FACES(FACES), .ENTRIES(ENTRIES)) u_search (
		.clk(clk), .arst_n(arst_n),
		.wr_en(take && op == OP_LOAD && 32'(face) < FACES && 32'(entry_index) < ENTRIES),
		.wr_addr((AW'(face) << IW) | AW'(entry_index)),
		.wr_data({glyph_advance, glyph_code}),
		.start(s_start),
		.base_addr(AW'(FW > 0 ? sface_q : 2'd0) << IW),
		.count(face_ok ? s_count : '0),
		.code(s_code),
		.ctl(s_ctl),
		.adv(s_adv)
	);

	assign sum = {1'b0, rw_q} + (WIDTH_W+1)'(s_adv);
	assign new_rw = sum[WIDTH_W] ? WIDTH_MAX : sum[WIDTH_W-1:0];
	assign is_cont = (byte_q[7:6] == 2'b10);
	always_comb begin
		if (byte_q[7:5] == 3'b110) begin
			lead_extra = 2'd1; lead_code = CODE_W'(byte_q[4:0]);
		end else if (byte_q[7:4] == 4'b1110) begin
			lead_extra = 2'd2; lead_code = CODE_W'(byte_q[3:0]);
		end else if (byte_q[7:3] == 5'b11110) begin
			lead_extra = 2'd3; lead_code = CODE_W'(byte_q[2:0]);
		end else begin
			lead_extra = 2'd0; lead_code = CODE_W'(byte_q);
		end
	end

	// Sequencer: OPEN searches the ellipsis, PROC handles one byte step,
	// FINISH waits for a code point search and commits it.
	always_comb begin
		state_d = state_q;
		s_start = 1'b0;
		s_code = pcode_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && (op == OP_BYTE || op == OP_END)) begin
					state_d = instr_q ? ST_PROC : ST_OPEN;
				end
			end
			ST_OPEN: begin
				if (!s_ctl.busy && !s_ctl.done) begin
					s_start = 1'b1;
					s_code = ELLIPSIS_CODE;
				end
				if (s_ctl.done) state_d = ST_PROC;
			end
			ST_PROC: begin
				if (op_q == OP_END) begin
					if (pextra_q != 2'd0) begin
						s_start = 1'b1; state_d = ST_FINISH;
					end else begin
						state_d = ST_OUT;
					end
				end else if (32'(boff_q) >= CAP) begin
					state_d = ST_IDLE;
				end else if (pextra_q != 2'd0 && !is_cont) begin
					s_start = 1'b1; state_d = ST_FINISH;
				end else if (pextra_q != 2'd0) begin
					if (pextra_q == 2'd1) begin
						s_start = 1'b1;
						s_code = (CODE_W'({pcode_q, 6'b0}) | CODE_W'(byte_q[5:0]));
						state_d = ST_FINISH;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (lead_extra == 2'd0) begin
					s_start = 1'b1; s_code = lead_code; state_d = ST_FINISH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (s_ctl.done) begin
					if (fin_end_q) state_d = (op_q == OP_END) ? ST_OUT : ST_IDLE;
					else state_d = ST_PROC;
				end
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
			pcode_q <= '0; pextra_q <= '0; boff_q <= '0; taken_q <= '0;
			rw_q <= '0; room_q <= '0; instr_q <= 1'b0; broken_q <= 1'b0;
			ovf_q <= 1'b0; sface_q <= '0; savail_q <= '0;
			fin_end_q <= 1'b0; fin_at_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) cnt_q[cfg_index] <= cfg_data;
			if (take) begin
				op_q <= op;
				byte_q <= text_byte;
				if (!instr_q && (op == OP_BYTE || op == OP_END)) begin
					instr_q <= 1'b1;
					sface_q <= face;
					savail_q <= avail_width;
				end
			end
			if (state_q == ST_OPEN && s_ctl.done) begin
				room_q <= $signed({2'b00, savail_q}) - $signed(ROOM_W'(s_adv));
			end
			if (state_q == ST_PROC) begin
				if (op_q == OP_END) begin
					fin_end_q <= 1'b1; fin_at_q <= boff_q;
				end else if (32'(boff_q) >= CAP) begin
					ovf_q <= 1'b1;
				end else if (pextra_q != 2'd0 && !is_cont) begin
					fin_end_q <= 1'b0; fin_at_q <= boff_q;
				end else if (pextra_q != 2'd0) begin
					pcode_q <= CODE_W'({pcode_q, 6'b0}) | CODE_W'(byte_q[5:0]);
					pextra_q <= pextra_q - 1'b1;
					boff_q <= boff_q + 1'b1;
					fin_end_q <= 1'b1; fin_at_q <= boff_q + 1'b1;
				end else begin
					pcode_q <= lead_code;
					pextra_q <= lead_extra;
					boff_q <= boff_q + 1'b1;
					fin_end_q <= 1'b1; fin_at_q <= boff_q + 1'b1;
				end
			end
			if (state_q == ST_FINISH && s_ctl.done) begin
				rw_q <= new_rw;
				if (!broken_q) begin
					if ($signed({1'b0, new_rw}) > $signed(room_q)) broken_q <= 1'b1;
					else taken_q <= fin_at_q;
				end
				pcode_q <= '0;
				pextra_q <= '0;
			end
			if (state_q == ST_OUT && !out_stall) begin
				pcode_q <= '0; pextra_q <= '0; boff_q <= '0; taken_q <= '0;
				rw_q <= '0; room_q <= '0; instr_q <= 1'b0; broken_q <= 1'b0;
				ovf_q <= 1'b0; sface_q <= '0; savail_q <= '0;
			end
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign whole_fits = (rw_q <= WIDTH_W'(savail_q));
	assign fit_bytes = whole_fits ? boff_q : taken_q;
	assign total_width = rw_q;
	assign too_long = ovf_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(fit_bytes)))
		else $error("result dropped under stall");
	a_taken_le: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= boff_q) else $error("prefix beyond byte count");
endmodule
